[rtl/amss_pkg.sv]
// Package for the alternating max subarray sum tree.
// Node type, state type, widths, constants and a signed max; no dependencies.
`timescale 1ns / 1ps
package amss_pkg;
    localparam int LEAVES_DEF = 1024;
    localparam int NW = 48;
    localparam int OW = 42;
    localparam int LW = 11;

    typedef struct packed {
        logic signed [NW-1:0] total;
        logic signed [NW-1:0] prefix;
        logic signed [NW-1:0] suffix;
        logic signed [NW-1:0] best;
    } t_node;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_UDESC, S_UREAD, S_UWAIT, S_UMERGE,
        S_QPOP, S_QWAIT, S_QACC, S_QDONE
    } t_state;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    function automatic logic signed [NW-1:0] smax(input logic signed [NW-1:0] a,
                                                    input logic signed [NW-1:0] b);
        return (a > b) ? a : b;
    endfunction
endpackage

[rtl/alternating_max_subarray_sum_tree.sv]
// Top level: two segment trees, one node memory per tree, read-modify-write walks.
// Depends on amss_pkg.
// Update: walk down and write the leaf, then merge back up to the root level by level.
// Query: node-stack walk, each node via S_QPOP, S_QWAIT and S_QACC, then S_QDONE.
// One item at a time; busy is high while working. Result strobe is one cycle, no stall.
// Reset and an accepted used_length write clear all 4*LEAVES nodes, busy held.
`timescale 1ns / 1ps
module alternating_max_subarray_sum_tree
    import amss_pkg::*;
#(
    parameter int LEAVES = LEAVES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_command,
    input  logic [LW-1:0]        i_position,
    input  logic signed [31:0]   i_value,
    input  logic [LW-1:0]        i_query_left,
    input  logic [LW-1:0]        i_query_right,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [LW-1:0]        i_cfg_data,
    output logic                 o_best_valid,
    output logic signed [OW-1:0] o_best_sum
);
    localparam int NODES = 4 * LEAVES;
    localparam int AW = $clog2(NODES);
    localparam int DW = $clog2(LEAVES) + 2;
    localparam int SD = 2 * DW + 2;
    localparam int SW = $clog2(SD + 1);
    localparam int XW = (LW > $clog2(LEAVES + 1) + 1) ? LW : $clog2(LEAVES + 1) + 1;

    typedef struct packed {
        logic [AW:0]   nd;
        logic [XW-1:0] lo;
        logic [XW-1:0] hi;
    } t_frame;

    t_node mem_a [NODES];
    t_node mem_b [NODES];
    logic [AW-1:0] mem_raddr, mem_waddr;
    logic          mem_we;
    t_node         wd_a, wd_b, rd_a, rd_b;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_a[mem_waddr] <= wd_a;
            mem_b[mem_waddr] <= wd_b;
        end
        rd_a <= mem_a[mem_raddr];
        rd_b <= mem_b[mem_raddr];
    end

    t_state r_state, n_state;
    logic [XW-1:0] r_len, n_len;
    logic [AW:0]   r_cnt, n_cnt;
    logic [XW-1:0] r_lo, n_lo, r_hi, n_hi, r_pos, n_pos, r_l, n_l, r_r, n_r;
    logic [AW:0]   r_nd, n_nd;
    logic signed [NW-1:0] r_va, n_va;
    t_node r_ca, n_ca, r_cb, n_cb;
    logic          r_side, n_side;
    t_frame        r_stk [SD];
    t_frame        push_f;
    logic          push2;
    t_frame        push_f2;
    logic [SW-1:0] r_sp, n_sp;
    logic signed [NW-1:0] r_ba, n_ba, r_sa, n_sa, r_bb, n_bb, r_sb, n_sb;
    logic          r_ov, n_ov;
    logic signed [OW-1:0] r_res, n_res;
    logic          stk_we;

    logic [XW-1:0] mid;
    logic signed [NW-1:0] leafv, res_m;
    logic [XW-1:0] cfg_v;
    t_frame top;

    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign o_best_valid = r_ov;
    assign o_best_sum = r_res;
    assign top = r_stk[r_sp[SW-1:0] - SW'(1)];
    assign mid = XW'((r_lo + r_hi) >> 1);

    function automatic t_node merge(input t_node a, input t_node b);
        t_node m;
        m.total  = a.total + b.total;
        m.prefix = smax(a.prefix, a.total + b.prefix);
        m.suffix = smax(b.suffix, b.total + a.suffix);
        m.best   = smax(smax(a.best, b.best), a.suffix + b.prefix);
        return m;
    endfunction

    always_comb begin
        cfg_v = XW'(i_cfg_data);
        if (cfg_v == '0) cfg_v = XW'(1);
        if (cfg_v > XW'(LEAVES)) cfg_v = XW'(LEAVES);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_cnt == (AW+1)'(NODES - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (start) begin
                    if (i_command == CMD_UPDATE) begin
                        if (i_position != '0 && XW'(i_position) <= r_len)
                            n_state = S_UDESC;
                    end else n_state = S_QPOP;
                end else if (i_cfg_valid) n_state = S_CLEAR;
            end
            S_UDESC: n_state = (r_lo == r_hi) ? S_UREAD : S_UDESC;
            S_UREAD: n_state = (r_nd == (AW+1)'(1)) ? S_IDLE : S_UWAIT;
            S_UWAIT: n_state = S_UMERGE;
            S_UMERGE: n_state = S_UREAD;
            S_QPOP: n_state = (r_sp == '0) ? S_QDONE : S_QWAIT;
            S_QWAIT: n_state = S_QACC;
            S_QACC: n_state = S_QPOP;
            S_QDONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_len = r_len; n_cnt = r_cnt; n_lo = r_lo; n_hi = r_hi; n_pos = r_pos;
        n_l = r_l; n_r = r_r; n_nd = r_nd; n_va = r_va; n_ca = r_ca; n_cb = r_cb;
        n_side = r_side; n_sp = r_sp; n_ba = r_ba; n_sa = r_sa; n_bb = r_bb;
        n_sb = r_sb; n_ov = 1'b0; n_res = r_res;
        mem_raddr = r_nd[AW-1:0]; mem_waddr = r_nd[AW-1:0]; mem_we = 1'b0;
        wd_a = '0; wd_b = '0; stk_we = 1'b0; push2 = 1'b0;
        push_f = '0; push_f2 = '0;
        leafv = NW'(r_va); res_m = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1; mem_waddr = r_cnt[AW-1:0];
                n_cnt = r_cnt + 1'b1;
            end
            S_IDLE: begin
                n_cnt = '0;
                if (start) begin
                    n_lo = XW'(1); n_hi = r_len; n_nd = (AW+1)'(1);
                    n_pos = XW'(i_position);
                    n_va = NW'(i_value);
                    n_l = (i_query_left == '0) ? XW'(1) : XW'(i_query_left);
                    n_r = (XW'(i_query_right) > r_len) ? r_len : XW'(i_query_right);
                    n_ba = {1'b1, {(NW-1){1'b0}}}; n_bb = {1'b1, {(NW-1){1'b0}}};
                    n_sa = '0; n_sb = '0;
                    n_sp = '0;
                    if (i_command == CMD_QUERY) begin
                        stk_we = 1'b1; n_sp = SW'(1);
                        push_f.nd = (AW+1)'(1); push_f.lo = XW'(1); push_f.hi = r_len;
                        if (n_l > n_r) n_sp = '0;
                    end
                end else if (i_cfg_valid) n_len = cfg_v;
            end
            S_UDESC: begin
                if (r_lo == r_hi) begin
                    leafv = r_pos[0] ? r_va : -r_va;
                    mem_we = 1'b1;
                    wd_a = '{leafv, leafv, leafv, leafv};
                    wd_b = '{-leafv, -leafv, -leafv, -leafv};
                    n_ca = wd_a; n_cb = wd_b;
                    n_side = r_nd[0];
                end else if (r_pos <= mid) begin
                    n_nd = {r_nd[AW-1:0], 1'b0}; n_hi = mid;
                end else begin
                    n_nd = {r_nd[AW-1:0], 1'b1}; n_lo = mid + 1'b1;
                end
            end
            S_UREAD: begin
                mem_raddr = {r_nd[AW-1:1], ~r_nd[0]};
                n_side = r_nd[0];
                n_nd = r_nd >> 1;
            end
            // keep the sibling on the read port until the merge
            S_UWAIT: mem_raddr = {r_nd[AW-2:0], ~r_side};
            S_UMERGE: begin
                mem_we = 1'b1;
                wd_a = r_side ? merge(rd_a, r_ca) : merge(r_ca, rd_a);
                wd_b = r_side ? merge(rd_b, r_cb) : merge(r_cb, rd_b);
                n_ca = wd_a; n_cb = wd_b;
            end
            S_QPOP: begin
                if (r_sp != '0) begin
                    mem_raddr = top.nd[AW-1:0];
                    n_nd = top.nd; n_lo = top.lo; n_hi = top.hi;
                    n_sp = r_sp - 1'b1;
                end
            end
            S_QWAIT: ;
            S_QACC: begin
                if (r_l <= r_lo && r_hi <= r_r) begin
                    n_ba = smax(r_ba, smax(rd_a.best, r_sa + rd_a.prefix));
                    n_sa = smax(r_sa + rd_a.total, rd_a.suffix);
                    n_bb = smax(r_bb, smax(rd_b.best, r_sb + rd_b.prefix));
                    n_sb = smax(r_sb + rd_b.total, rd_b.suffix);
                end else if (r_lo != r_hi) begin
                    // push right child first so left is walked first
                    if (mid < r_r) begin
                        stk_we = 1'b1;
                        push_f.nd = {r_nd[AW-1:0], 1'b1};
                        push_f.lo = mid + 1'b1; push_f.hi = r_hi;
                    end
                    if (r_l <= mid) begin
                        push2 = 1'b1;
                        push_f2.nd = {r_nd[AW-1:0], 1'b0};
                        push_f2.lo = r_lo; push_f2.hi = mid;
                    end
                    n_sp = r_sp + SW'(stk_we) + SW'(push2);
                end
            end
            S_QDONE: begin
                n_ov = 1'b1;
                res_m = smax(r_ba, r_bb);
                if (r_sp == '0 && r_l > r_r) n_res = {1'b1, {(OW-1){1'b0}}};
                else if (res_m < -(NW'(1) <<< (OW-1))) n_res = {1'b1, {(OW-1){1'b0}}};
                else if (res_m > (NW'(1) <<< (OW-1)) - 1) n_res = {1'b0, {(OW-1){1'b1}}};
                else n_res = OW'(res_m);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            if (r_state == S_IDLE) r_stk[0] <= push_f;
            else r_stk[r_sp] <= push_f;
        end
        if (push2) r_stk[r_sp + SW'(stk_we)] <= push_f2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_len <= XW'(LEAVES); r_cnt <= '0; r_sp <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_len <= n_len; r_cnt <= n_cnt; r_sp <= n_sp;
            r_ov <= n_ov;
        end
        r_lo <= n_lo; r_hi <= n_hi; r_pos <= n_pos; r_l <= n_l; r_r <= n_r;
        r_nd <= n_nd; r_va <= n_va; r_ca <= n_ca; r_cb <= n_cb; r_side <= n_side;
        r_ba <= n_ba; r_sa <= n_sa; r_bb <= n_bb; r_sb <= n_sb; r_res <= n_res;
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !busy) else $error("cfg ready while busy");
    a_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_best_valid |=> !o_best_valid) else $error("result strobe too long");
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SW'(SD)) else $error("walk stack overflow");
    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> busy) else $error("no clear after cfg");
endmodule

[tb/amss_checker.sv]
// Checker for the alternating max subarray sum tree: watches items, queries and
// register writes, predicts best_sum with its own pair of trees. Depends on amss_pkg.
`timescale 1ns / 1ps
module amss_checker
    import amss_pkg::*;
#(
    parameter int LEAVES = LEAVES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic                 i_command,
    input  logic [LW-1:0]        i_position,
    input  logic signed [31:0]   i_value,
    input  logic [LW-1:0]        i_query_left,
    input  logic [LW-1:0]        i_query_right,
    input  logic                 i_cfg_valid,
    input  logic                 o_cfg_ready,
    input  logic [LW-1:0]        i_cfg_data,
    input  logic                 o_best_valid,
    input  logic signed [OW-1:0] o_best_sum,
    output int                   o_fail_count,
    output int                   o_pending
);
    localparam int NODES = 4 * LEAVES;
    localparam longint SUM_MIN = -(64'sd1 <<< 41);
    localparam longint SUM_MAX = (64'sd1 <<< 41) - 1;

    longint odd_tot[NODES], odd_pre[NODES], odd_suf[NODES], odd_bst[NODES];
    longint evn_tot[NODES], evn_pre[NODES], evn_suf[NODES], evn_bst[NODES];
    int unsigned span;
    longint walk_best, walk_suf;
    logic signed [OW-1:0] best_sum_q[$];

    function automatic longint lmax(longint a, longint b);
        return a > b ? a : b;
    endfunction

    task automatic clear_trees();
        for (int k = 0; k < NODES; k++) begin
            odd_tot[k] = 0; odd_pre[k] = 0; odd_suf[k] = 0; odd_bst[k] = 0;
            evn_tot[k] = 0; evn_pre[k] = 0; evn_suf[k] = 0; evn_bst[k] = 0;
        end
    endtask

    // sel 0 = plus-odd tree, 1 = plus-even tree
    task automatic write_leaf(bit sel, int unsigned nd, int unsigned lo, int unsigned hi,
                              int unsigned pos, longint v);
        int unsigned mid, a, b;
        longint t, p, s, bs;
        if (nd >= NODES) return;
        if (lo == hi) begin
            if (sel) begin
                evn_tot[nd] = v; evn_pre[nd] = v; evn_suf[nd] = v; evn_bst[nd] = v;
            end else begin
                odd_tot[nd] = v; odd_pre[nd] = v; odd_suf[nd] = v; odd_bst[nd] = v;
            end
            return;
        end
        if (2 * nd + 1 >= NODES) return;
        mid = (lo + hi) / 2;
        if (pos <= mid) write_leaf(sel, 2 * nd, lo, mid, pos, v);
        else write_leaf(sel, 2 * nd + 1, mid + 1, hi, pos, v);
        a = 2 * nd;
        b = 2 * nd + 1;
        if (sel) begin
            t = evn_tot[a] + evn_tot[b];
            p = lmax(evn_pre[a], evn_tot[a] + evn_pre[b]);
            s = lmax(evn_suf[b], evn_tot[b] + evn_suf[a]);
            bs = lmax(lmax(evn_bst[a], evn_bst[b]), evn_suf[a] + evn_pre[b]);
            evn_tot[nd] = t; evn_pre[nd] = p; evn_suf[nd] = s; evn_bst[nd] = bs;
        end else begin
            t = odd_tot[a] + odd_tot[b];
            p = lmax(odd_pre[a], odd_tot[a] + odd_pre[b]);
            s = lmax(odd_suf[b], odd_tot[b] + odd_suf[a]);
            bs = lmax(lmax(odd_bst[a], odd_bst[b]), odd_suf[a] + odd_pre[b]);
            odd_tot[nd] = t; odd_pre[nd] = p; odd_suf[nd] = s; odd_bst[nd] = bs;
        end
    endtask

    task automatic range_walk(bit sel, int unsigned nd, int unsigned lo, int unsigned hi,
                              int unsigned l, int unsigned r);
        int unsigned mid;
        longint t, p, s, bs;
        if (nd >= NODES) return;
        if (l <= lo && hi <= r) begin
            t = sel ? evn_tot[nd] : odd_tot[nd];
            p = sel ? evn_pre[nd] : odd_pre[nd];
            s = sel ? evn_suf[nd] : odd_suf[nd];
            bs = sel ? evn_bst[nd] : odd_bst[nd];
            walk_best = lmax(walk_best, lmax(bs, walk_suf + p));
            walk_suf = lmax(walk_suf + t, s);
            return;
        end
        if (lo == hi) return;
        mid = (lo + hi) / 2;
        if (l <= mid) range_walk(sel, 2 * nd, lo, mid, l, r);
        if (mid < r) range_walk(sel, 2 * nd + 1, mid + 1, hi, l, r);
    endtask

    task automatic apply_item();
        int unsigned l, r;
        longint v, res;
        if (i_command == CMD_UPDATE) begin
            if (i_position < 1 || i_position > span) return;
            v = longint'(i_value);
            write_leaf(1'b0, 1, 1, span, i_position, i_position[0] ? v : -v);
            write_leaf(1'b1, 1, 1, span, i_position, i_position[0] ? -v : v);
            return;
        end
        l = (i_query_left < 1) ? 1 : i_query_left;
        r = (i_query_right > span) ? span : i_query_right;
        if (l > r) begin
            res = SUM_MIN;
        end else begin
            res = -(64'sd1 <<< 62);
            for (int sel = 0; sel < 2; sel++) begin
                walk_best = -(64'sd1 <<< 62);
                walk_suf = 0;
                range_walk(sel[0], 1, 1, span, l, r);
                res = lmax(res, walk_best);
            end
            if (res < SUM_MIN) res = SUM_MIN;
            if (res > SUM_MAX) res = SUM_MAX;
        end
        best_sum_q.push_back(res[OW-1:0]);
    endtask

    task automatic report(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        span = LEAVES;
        clear_trees();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            span = LEAVES;
            clear_trees();
            best_sum_q.delete();
        end else begin
            if (o_best_valid) begin
                if (best_sum_q.size() == 0) report("unexpected best_sum", o_best_sum, 0);
                else if (o_best_sum !== best_sum_q[0])
                    report("best_sum", o_best_sum, best_sum_q.pop_front());
                else void'(best_sum_q.pop_front());
            end
            if (start && !busy) apply_item();
            if (i_cfg_valid && o_cfg_ready) begin
                span = (i_cfg_data < 1) ? 1 : (i_cfg_data > LEAVES ? LEAVES : i_cfg_data);
                clear_trees();
            end
        end
        o_pending = best_sum_q.size();
    end
endmodule

[tb/testbench.sv]
// Top of the bench: clock, reset, stimulus and verdict for the alternating
// max subarray sum tree. Depends on amss_pkg, the block and amss_checker.
`timescale 1ns / 1ps
module testbench;
    import amss_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_command = CMD_UPDATE;
    logic [LW-1:0]        i_position = '0;
    logic signed [31:0]   i_value = '0;
    logic [LW-1:0]        i_query_left = '0;
    logic [LW-1:0]        i_query_right = '0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [LW-1:0]        i_cfg_data = '0;
    logic                 o_best_valid;
    logic signed [OW-1:0] o_best_sum;
    int                   fail_count;
    int                   pending;
    int unsigned          span = LEAVES_DEF;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    alternating_max_subarray_sum_tree i_dut (.*);

    amss_checker u_check (.o_fail_count(fail_count), .o_pending(pending), .*);

    task automatic send(logic cmd, logic [LW-1:0] pos, logic signed [31:0] val,
                        logic [LW-1:0] ql, logic [LW-1:0] qr);
        @(negedge i_clk);
        start <= 1'b1;
        i_command <= cmd;
        i_position <= pos;
        i_value <= val;
        i_query_left <= ql;
        i_query_right <= qr;
        do @(posedge i_clk); while (busy);
        // burst gaps
        if ($urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_span(logic [LW-1:0] n);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= n;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        span = (n < 1) ? 1 : (n > LEAVES_DEF ? LEAVES_DEF : n);
    endtask

    task automatic random_item();
        logic [LW-1:0] a, b;
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'sh7fffffff;
            1: v = 32'sh80000000;
            default: v = $urandom;
        endcase
        if ($urandom_range(0, 19) == 0) a = LW'($urandom);
        else a = LW'($urandom_range(1, span));
        b = ($urandom_range(0, 19) == 0) ? LW'($urandom) : LW'($urandom_range(1, span));
        if ($urandom_range(0, 1)) send(CMD_UPDATE, a, v, LW'($urandom), LW'($urandom));
        else if (a <= b) send(CMD_QUERY, LW'($urandom), $urandom, a, b);
        else send(CMD_QUERY, LW'($urandom), $urandom, b, a);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default size, extremes
        send(CMD_UPDATE, 1, 32'sh7fffffff, 0, 0);
        send(CMD_UPDATE, 2, 32'sh80000000, 0, 0);
        send(CMD_UPDATE, 1024, 32'sh80000000, 0, 0);
        send(CMD_UPDATE, 1023, 32'sh7fffffff, 0, 0);
        send(CMD_UPDATE, 0, 5, 0, 0);
        send(CMD_UPDATE, 11'h7ff, 5, 0, 0);
        send(CMD_QUERY, 0, 0, 0, 11'h7ff);
        send(CMD_QUERY, 0, 0, 1, 2);
        send(CMD_QUERY, 0, 0, 2, 2);
        send(CMD_QUERY, 0, 0, 1023, 1024);
        send(CMD_QUERY, 0, 0, 5, 4);
        send(CMD_QUERY, 0, 0, 11'h7ff, 11'h7ff);
        send(CMD_QUERY, 0, 0, 300, 700);
        set_span(0);
        send(CMD_UPDATE, 1, -7, 0, 0);
        send(CMD_UPDATE, 2, 3, 0, 0);
        send(CMD_QUERY, 0, 0, 1, 1);
        send(CMD_QUERY, 0, 0, 0, 11'h7ff);
        set_span(11'h7ff);
        send(CMD_QUERY, 0, 0, 1, 1024);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_span(2);
                1: set_span(7);
                2: set_span(1);
                3: set_span(LW'($urandom_range(3, 64)));
                4: set_span(1024);
                5: set_span(LW'($urandom_range(65, 1023)));
                6: set_span(16);
                default: set_span(1024);
            endcase
            repeat (200) random_item();
        end
        drain();
        if (fail_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule

[filelist.f]
rtl/amss_pkg.sv
rtl/alternating_max_subarray_sum_tree.sv
tb/amss_checker.sv
tb/testbench.sv
